### design/sia_pkg.sv
// Shared types, constants and bit helpers for the space ID allocator.
`timescale 1ns / 1ps

package sia_pkg;

    // Number of IDs handled. Keep it a multiple of WORD_W, at least 2 * WORD_W.
    localparam int ID_COUNT     = 4096;
    localparam int ID_W         = $clog2(ID_COUNT);
    localparam int BND_W        = ID_W + 1;
    localparam int WORD_W       = 32;
    localparam int BIT_W        = $clog2(WORD_W);
    localparam int WORDS        = ID_COUNT / WORD_W;
    localparam int WADDR_W      = $clog2(WORDS);
    localparam int REFILL_COUNT = 31;

    localparam int FUNC_W   = 1;
    localparam int REQ_ID_W = 13;
    localparam int RSP_ID_W = 12;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd3;

    // Release paths
    localparam logic [1:0] REL_ERR  = 2'd0;
    localparam logic [1:0] REL_TOP  = 2'd1;
    localparam logic [1:0] REL_FOLD = 2'd2;
    localparam logic [1:0] REL_SET  = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [REQ_ID_W-1:0] id_in;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RSP_ID_W-1:0] id_out;
    } rsp_t;

    typedef struct packed {
        logic clr;
        logic accept;
        logic alloc_start;
        logic alloc_take;
        logic wa_inc;
        logic pool;
        logic set_wr;
        logic rel_start;
        logic fold_chk;
        logic finish;
    } sia_cmd_t;

    typedef struct packed {
        logic       wa_last;
        logic       is_release;
        logic [1:0] rel_kind;
        logic       fold_zero;
        logic       word_nz;
        logic       pool_fill;
        logic       wa_at_hi;
        logic       fold_cont;
    } sia_stat_t;

    // Bits 0..p set
    function automatic logic [WORD_W-1:0] low_mask(input logic [BIT_W-1:0] p);
        logic [WORD_W-1:0] ones;
        ones = '1;
        return ones >> (BIT_W'(WORD_W - 1) - p);
    endfunction

    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [BIT_W-1:0] highest_set(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (w[i])
            begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

### design/sia_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/sia_dp.sv
// Datapath: free bitmap memory, boundary, exhausted flag and result registers.
`timescale 1ns / 1ps

module sia_dp import sia_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  sia_cmd_t  cmd,
    output sia_stat_t stat,
    input  req_t      req,
    output rsp_t      rsp
);

    logic [FUNC_W-1:0]   func_reg;
    logic [REQ_ID_W-1:0] sid_reg;
    logic [BND_W-1:0]    bnd_reg,  bnd_next;
    logic                exh_reg,  exh_next;
    logic [WADDR_W-1:0]  wa_reg,   wa_next;
    logic [ID_W-1:0]     lo_reg,   lo_next;
    logic [ID_W-1:0]     hi_reg,   hi_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ID_W-1:0]     res_id_reg,     res_id_next;
    rsp_t                rsp_reg;

    logic                we;
    logic [WORD_W-1:0]   wdata;
    logic [WORD_W-1:0]   rdata;

    logic [31:0]         sid32, bnd32, b1, b32, hi32;
    logic [1:0]          rel_kind;
    logic [STATUS_W-1:0] rel_err_status;
    logic [WORD_W-1:0]   set_mask;
    logic [BND_W-1:0]    tgt;
    logic [WADDR_W-1:0]  tw;
    logic [BIT_W-1:0]    p, h, run_low;
    logic [WORD_W-1:0]   lm, above_bits, zeros, run;
    logic                wa_above, fold_write, fold_cont;

    sia_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .clk   (clk),
        .we    (we),
        .waddr (wa_reg),
        .wdata (wdata),
        .raddr (wa_reg),
        .rdata (rdata)
    );

    // Release classification
    always_comb
    begin
        sid32 = 32'(sid_reg);
        bnd32 = 32'(bnd_reg);
        rel_err_status = (sid32 >= 32'(ID_COUNT)) ? ST_INVALID : ST_NOT_ALLOC;
        if (sid32 >= 32'(ID_COUNT))
        begin
            rel_kind = REL_ERR;
        end
        else if (!exh_reg && sid32 >= bnd32)
        begin
            rel_kind = REL_ERR;
        end
        else if (sid32 == 32'(ID_COUNT - 1))
        begin
            rel_kind = REL_TOP;
        end
        else if (!exh_reg && bnd32 != 32'd0 && sid32 == bnd32 - 32'd1)
        begin
            rel_kind = REL_FOLD;
        end
        else
        begin
            rel_kind = REL_SET;
        end
    end

    // Pool refill range
    always_comb
    begin
        b1   = bnd32 + 32'd1;
        b32  = bnd32 + 32'(REFILL_COUNT + 1);
        hi32 = (b32 - 32'd1 < 32'(ID_COUNT - 1)) ? b32 - 32'd1 : 32'(ID_COUNT - 1);
    end

    // Bits of the current word that fall in lo..hi
    always_comb
    begin
        for (int i = 0; i < WORD_W; i++)
        begin
            set_mask[i] = ({wa_reg, BIT_W'(i)} >= lo_reg) && ({wa_reg, BIT_W'(i)} <= hi_reg);
        end
    end

    // Fold-down: run of set bits from the bit under the boundary downward
    always_comb
    begin
        tgt        = bnd_reg - BND_W'(1);
        tw         = WADDR_W'(tgt >> BIT_W);
        p          = tgt[BIT_W-1:0];
        wa_above   = (wa_reg != tw);
        lm         = low_mask(p);
        above_bits = rdata & ~lm;
        zeros      = ~rdata & lm;
        h          = highest_set(zeros);
        if (zeros == '0)
        begin
            run     = lm;
            run_low = '0;
        end
        else
        begin
            run     = lm & ~low_mask(h);
            run_low = h + BIT_W'(1);
        end
        fold_write = !wa_above && (above_bits == '0) && (run != '0);
        if (wa_above)
        begin
            fold_cont = (rdata == '0);
        end
        else
        begin
            fold_cont = fold_write && (run_low == '0) && (wa_reg != '0);
        end
    end

    // Memory write port
    always_comb
    begin
        we    = cmd.clr || cmd.alloc_take || cmd.set_wr || (cmd.fold_chk && fold_write);
        wdata = '0;
        if (cmd.alloc_take)
        begin
            wdata = rdata & ~(WORD_W'(1) << lowest_set(rdata));
        end
        else if (cmd.set_wr)
        begin
            wdata = rdata | set_mask;
        end
        else if (cmd.fold_chk)
        begin
            wdata = rdata & ~run;
        end
    end

    always_comb
    begin
        bnd_next        = bnd_reg;
        exh_next        = exh_reg;
        wa_next         = wa_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;

        if (cmd.clr)
        begin
            wa_next = stat.wa_last ? '0 : wa_reg + WADDR_W'(1);
        end
        if (cmd.wa_inc)
        begin
            wa_next = wa_reg + WADDR_W'(1);
        end
        if (cmd.alloc_start)
        begin
            wa_next         = '0;
            res_status_next = ST_OK;
            res_id_next     = '0;
        end
        if (cmd.alloc_take)
        begin
            res_id_next = {wa_reg, lowest_set(rdata)};
        end
        if (cmd.pool)
        begin
            if (exh_reg)
            begin
                res_status_next = ST_EXHAUSTED;
            end
            else
            begin
                res_id_next = ID_W'(bnd_reg);
                if (!stat.pool_fill)
                begin
                    bnd_next = BND_W'(ID_COUNT);
                    exh_next = 1'b1;
                end
                else
                begin
                    lo_next = ID_W'(b1);
                    hi_next = ID_W'(hi32);
                    wa_next = WADDR_W'(b1 >> BIT_W);
                    if (b32 >= 32'(ID_COUNT))
                    begin
                        bnd_next = BND_W'(ID_COUNT);
                        exh_next = 1'b1;
                    end
                    else
                    begin
                        bnd_next = BND_W'(b32);
                    end
                end
            end
        end
        if (cmd.rel_start)
        begin
            res_status_next = ST_OK;
            res_id_next     = '0;
            case (rel_kind)
                REL_ERR:
                begin
                    res_status_next = rel_err_status;
                end
                REL_TOP:
                begin
                    bnd_next = BND_W'(ID_COUNT - 1);
                    exh_next = 1'b0;
                end
                REL_FOLD:
                begin
                    bnd_next = BND_W'(sid_reg);
                    wa_next  = WADDR_W'(WORDS - 1);
                end
                REL_SET:
                begin
                    lo_next = ID_W'(sid_reg);
                    hi_next = ID_W'(sid_reg);
                    wa_next = WADDR_W'(sid32 >> BIT_W);
                end
                default:
                begin
                    res_status_next = rel_err_status;
                end
            endcase
        end
        if (cmd.fold_chk)
        begin
            if (fold_write)
            begin
                bnd_next = BND_W'({wa_reg, run_low});
            end
            if (fold_cont)
            begin
                wa_next = wa_reg - WADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bnd_reg <= '0;
            exh_reg <= 1'b0;
            wa_reg  <= '0;
        end
        else
        begin
            bnd_reg <= bnd_next;
            exh_reg <= exh_next;
            wa_reg  <= wa_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= req.func;
            sid_reg  <= req.id_in;
        end
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        if (cmd.finish)
        begin
            rsp_reg.status <= res_status_reg;
            rsp_reg.id_out <= RSP_ID_W'(res_id_reg);
        end
    end

    always_comb
    begin
        stat.wa_last    = (wa_reg == WADDR_W'(WORDS - 1));
        stat.is_release = (func_reg == FUNC_RELEASE);
        stat.rel_kind   = rel_kind;
        stat.fold_zero  = (sid_reg == '0);
        stat.word_nz    = (rdata != '0);
        stat.pool_fill  = !exh_reg && (b1 < 32'(ID_COUNT));
        stat.wa_at_hi   = (wa_reg == WADDR_W'(hi_reg >> BIT_W));
        stat.fold_cont  = fold_cont;
    end

    assign rsp = rsp_reg;

endmodule

### design/sia_ctrl.sv
// Controller: sequences clearing, search, refill and fold-down, and the handshakes.
`timescale 1ns / 1ps

module sia_ctrl import sia_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    input  sia_stat_t stat,
    output sia_cmd_t  cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_ARD    = 4'd3;
    localparam logic [3:0] S_ACHK   = 4'd4;
    localparam logic [3:0] S_POOL   = 4'd5;
    localparam logic [3:0] S_SRD    = 4'd6;
    localparam logic [3:0] S_SWR    = 4'd7;
    localparam logic [3:0] S_FRD    = 4'd8;
    localparam logic [3:0] S_FCHK   = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       out_free;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.wa_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!stat.is_release)
                begin
                    cmd.alloc_start = 1'b1;
                    state_next      = S_ARD;
                end
                else
                begin
                    cmd.rel_start = 1'b1;
                    case (stat.rel_kind)
                        REL_FOLD: state_next = stat.fold_zero ? S_DONE : S_FRD;
                        REL_SET:  state_next = S_SRD;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_ARD:
            begin
                state_next = S_ACHK;
            end
            S_ACHK:
            begin
                if (stat.word_nz)
                begin
                    cmd.alloc_take = 1'b1;
                    state_next     = S_DONE;
                end
                else if (stat.wa_last)
                begin
                    state_next = S_POOL;
                end
                else
                begin
                    cmd.wa_inc = 1'b1;
                    state_next = S_ARD;
                end
            end
            S_POOL:
            begin
                cmd.pool   = 1'b1;
                state_next = stat.pool_fill ? S_SRD : S_DONE;
            end
            S_SRD:
            begin
                state_next = S_SWR;
            end
            S_SWR:
            begin
                cmd.set_wr = 1'b1;
                if (stat.wa_at_hi)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.wa_inc = 1'b1;
                    state_next = S_SRD;
                end
            end
            S_FRD:
            begin
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                cmd.fold_chk = 1'b1;
                state_next   = stat.fold_cont ? S_FRD : S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

### design/space_id_allocator.sv
// Top level of the space ID allocator: controller plus bitmap datapath.
`timescale 1ns / 1ps
// Sequence, request transfer to valid result: allocate decodes, then reads and checks each
//   bitmap word scanned (up to WORDS = 128), and taps the pool when none is free; release
//   decodes, then may set its bit or walk the boundary down word by word when it folds down.
// Throughput: one transfer at a time; the walk over the bitmap RAM sets the rate.
// Reset: boundary 0, exhausted clear; a clearing pass over all WORDS words zeroes the
//   bitmap while the request side stalls.

module space_id_allocator import sia_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    sia_cmd_t  cmd;
    sia_stat_t stat;

    // Sequence the walk over the bitmap and own both handshakes
    sia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold the bitmap, boundary and result; act on one command per cycle
    sia_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp)
    );

`ifndef SYNTHESIS
    // An accepted request keeps the block busy for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) cmd.accept |=> req_stall)
        else $error("request side open right after a transfer");

    // A result is never loaded over one that is still stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(rsp_valid && rsp_stall))
        else $error("result overwritten while stalled");

    // A finished result shows up on the response side
    assert property (@(posedge clk) disable iff (!rst_n) cmd.finish |=> rsp_valid)
        else $error("finished result not presented");
`endif

endmodule
